// ===== src/pcb_pkg.sv =====
package pcb_pkg;

   localparam int NUM_CHAN   = 3;
   localparam int PIX_W      = 8;
   localparam int WORK_W     = 2 * PIX_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // 1 luma, 1 operand select, 1 numerator product, 4 divide, 1 blend product,
   // 1 blend add, 1 premultiply/output
   localparam int DIV_STAGES = 4;
   localparam int NUM_STAGES = DIV_STAGES + 6;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
   localparam logic [PIX_W-1:0] LUMA_R  = 8'd77;
   localparam logic [PIX_W-1:0] LUMA_G  = 8'd151;
   localparam logic [PIX_W-1:0] LUMA_B  = 8'd28;

   typedef logic [PIX_W-1:0]          pix_type;
   typedef pix_type [NUM_CHAN-1:0]    rgb_type;
   typedef logic [WORK_W-1:0]         work_type;
   typedef work_type [NUM_CHAN-1:0]   rgb_work_type;

   typedef struct packed {
      rgb_type src;
      pix_type alpha;
   } pixel_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TINT_RED   = 3'd0,
      CSR_TINT_GREEN = 3'd1,
      CSR_TINT_BLUE  = 3'd2,
      CSR_STRENGTH   = 3'd3,
      CSR_GRAY_PIVOT = 3'd4
   } csr_index_type;

   // One restoring step: upper byte is the partial remainder, lower byte
   // shifts out dividend bits and shifts in quotient bits.
   function automatic work_type div_step(work_type w, pix_type d);
      logic [PIX_W:0] r2;
      logic [PIX_W:0] diff;
      r2   = {w[WORK_W-1:PIX_W], w[PIX_W-1]};
      diff = r2 - {1'b0, d};
      if (r2 >= {1'b0, d}) begin
         div_step = {diff[PIX_W-1:0], w[PIX_W-2:0], 1'b1};
      end else begin
         div_step = {r2[PIX_W-1:0], w[PIX_W-2:0], 1'b0};
      end
   endfunction

endpackage

// ===== src/pixel_colorize_blend_core.sv =====
// Channel    | Direction | Handshake             | Payload
// req_       | in        | req_valid / req_stall | req_in_red, _green, _blue, _alpha
// rsp_       | out       | rsp_valid / rsp_stall | rsp_out_red, _green, _blue, _alpha
// csr_       | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// Ten-stage pipeline; one pixel per cycle is sustained while rsp_stall is low. The pixel
// is registered in every stage and leaves from the output register. The four
// restoring-divide stages (two quotient bits each) set the depth. Synchronous active-high
// reset clears the valid bits and loads the register reset values. Each stage advances
// when the stage ahead is empty or advancing, so bubbles collapse and req_stall rises
// only with all stages full and rsp_stall high. csr_ready is always high.
module pixel_colorize_blend_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pcb_pkg::pix_type      req_in_red,
   input  pcb_pkg::pix_type      req_in_green,
   input  pcb_pkg::pix_type      req_in_blue,
   input  pcb_pkg::pix_type      req_in_alpha,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pcb_pkg::pix_type      rsp_out_red,
   output pcb_pkg::pix_type      rsp_out_green,
   output pcb_pkg::pix_type      rsp_out_blue,
   output pcb_pkg::pix_type      rsp_out_alpha,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [pcb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pcb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pcb_pkg::*;

   localparam int ST_LUMA  = 0;
   localparam int ST_OPS   = 1;
   localparam int ST_MUL   = 2;
   localparam int ST_BLEND = ST_MUL + DIV_STAGES + 1;
   localparam int ST_MIX   = ST_BLEND + 1;
   localparam int ST_OUT   = ST_MIX + 1;

   // configuration
   rgb_type tint_ff;
   pix_type strength_ff;
   pix_type pivot_ff;

   // pipeline control
   logic [NUM_STAGES-1:0] v_ff;
   logic [NUM_STAGES-1:0] v_in;
   logic [NUM_STAGES-1:0] en;

   // stage payloads
   pixel_type    s1_pix_ff;
   pix_type      s1_ga_ff;
   pixel_type    s2_pix_ff;
   logic [PIX_W:0] s2_a1_ff;
   pix_type      s2_a2_ff;
   logic         s2_sel_src_ff;
   logic         s2_plain_ff;
   pix_type      s2_div_ff;
   rgb_work_type dv_work_ff [DIV_STAGES+1];
   pix_type      dv_div_ff  [DIV_STAGES+1];
   pixel_type    dv_pix_ff  [DIV_STAGES+1];
   rgb_type      s8_scaled_ff;
   pixel_type    s8_pix_ff;
   rgb_type      s9_mix_ff;
   pix_type      s9_alpha_ff;
   rgb_type      rsp_rgb_ff;
   pix_type      rsp_alpha_ff;

   // combinational
   logic [WORK_W-1:0] luma_sum;
   pix_type       gray_eff;
   logic          plain_mode;
   logic          low_side;
   pix_type       span;
   pix_type       above;
   pix_type       below;
   logic [PIX_W:0] ga_round;
   logic [PIX_W:0] a1_in;
   pix_type       a2_in;
   logic          sel_src_in;
   pix_type       div_in;
   rgb_work_type  num_in;
   rgb_work_type  work_step_in [DIV_STAGES+1];
   logic [PIX_W:0] k_scale;
   rgb_type       scaled_in;
   rgb_type       mix_in;
   logic [PIX_W:0] alpha_round;
   rgb_type       prem_in;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tint_ff     <= '0;
         strength_ff <= PIX_MAX;
         pivot_ff    <= PIX_MAX;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TINT_RED:   tint_ff[0]  <= csr_wdata[PIX_W-1:0];
            CSR_TINT_GREEN: tint_ff[1]  <= csr_wdata[PIX_W-1:0];
            CSR_TINT_BLUE:  tint_ff[2]  <= csr_wdata[PIX_W-1:0];
            CSR_STRENGTH:   strength_ff <= csr_wdata[PIX_W-1:0];
            CSR_GRAY_PIVOT: pivot_ff    <= csr_wdata[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------ pipeline control
   always_comb begin
      en[NUM_STAGES-1] = !v_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
      v_in[0] = en[0] ? req_valid : v_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         v_in[i] = en[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = v_ff[ST_OUT];

   // ------------------------------------------------------------ stage 1: luma
   assign luma_sum = WORK_W'(LUMA_R) * WORK_W'(req_in_red)
                   + WORK_W'(LUMA_G) * WORK_W'(req_in_green)
                   + WORK_W'(LUMA_B) * WORK_W'(req_in_blue);

   always_ff @(posedge clock) begin
      if (en[ST_LUMA]) begin
         s1_pix_ff.src   <= {req_in_blue, req_in_green, req_in_red};
         s1_pix_ff.alpha <= req_in_alpha;
         s1_ga_ff        <= luma_sum[WORK_W-1:PIX_W];
      end
   end

   // -------------------------------------------- stage 2: tone mode, operands
   always_comb begin
      gray_eff   = (pivot_ff == '0) ? PIX_W'(1) : pivot_ff;
      plain_mode = (pivot_ff == PIX_MAX);
      low_side   = (s1_ga_ff <= gray_eff);
      span       = PIX_MAX - gray_eff;
      above      = s1_ga_ff - gray_eff;
      below      = span - above;
      ga_round   = {1'b0, s1_ga_ff} + (PIX_W+1)'(s1_ga_ff[PIX_W-1]);
      if (plain_mode) begin
         // divide by one passes the high byte straight through
         a1_in      = ga_round;
         a2_in      = '0;
         sel_src_in = 1'b0;
         div_in     = PIX_W'(1);
      end else if (low_side) begin
         a1_in      = {1'b0, s1_ga_ff};
         a2_in      = '0;
         sel_src_in = 1'b0;
         div_in     = gray_eff;
      end else begin
         a1_in      = {1'b0, above};
         a2_in      = below;
         sel_src_in = 1'b1;
         div_in     = span;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_OPS]) begin
         s2_pix_ff     <= s1_pix_ff;
         s2_a1_ff      <= a1_in;
         s2_a2_ff      <= a2_in;
         s2_sel_src_ff <= sel_src_in;
         s2_plain_ff   <= plain_mode;
         s2_div_ff     <= div_in;
      end
   end

   // ----------------------------------------------- stage 3: numerator product
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         num_in[c] = WORK_W'((WORK_W+1)'(s2_a1_ff)
                   * (WORK_W+1)'(s2_sel_src_ff ? s2_pix_ff.src[c] : tint_ff[c])
                   + (WORK_W+1)'(s2_a2_ff) * (WORK_W+1)'(tint_ff[c]));
         if (s2_plain_ff) begin
            num_in[c] = {{PIX_W{1'b0}}, num_in[c][WORK_W-1:PIX_W]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_MUL]) begin
         dv_work_ff[0] <= num_in;
         dv_div_ff[0]  <= s2_div_ff;
         dv_pix_ff[0]  <= s2_pix_ff;
      end
   end

   // ------------------------------------------ stages 4-7: restoring divide
   always_comb begin
      work_step_in[0] = dv_work_ff[0];
      for (int j = 1; j <= DIV_STAGES; j++) begin
         for (int c = 0; c < NUM_CHAN; c++) begin
            work_step_in[j][c] = div_step(div_step(dv_work_ff[j-1][c], dv_div_ff[j-1]),
                                          dv_div_ff[j-1]);
         end
      end
   end

   for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
      always_ff @(posedge clock) begin
         if (en[ST_MUL+j]) begin
            dv_work_ff[j] <= work_step_in[j];
            dv_div_ff[j]  <= dv_div_ff[j-1];
            dv_pix_ff[j]  <= dv_pix_ff[j-1];
         end
      end
   end

   // ------------------------------------------- stage 8: strength product
   always_comb begin
      logic signed [PIX_W:0]     diff;
      logic signed [2*PIX_W+2:0] prod;
      k_scale = {1'b0, strength_ff} + (PIX_W+1)'(strength_ff[PIX_W-1]);
      for (int c = 0; c < NUM_CHAN; c++) begin
         diff = $signed({1'b0, dv_work_ff[DIV_STAGES][c][PIX_W-1:0]})
              - $signed({1'b0, dv_pix_ff[DIV_STAGES].src[c]});
         prod = $signed({1'b0, k_scale}) * diff;
         // low byte of the floor shift; upper bits are dropped by the mask
         scaled_in[c] = prod[2*PIX_W-1:PIX_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_BLEND]) begin
         s8_scaled_ff <= scaled_in;
         s8_pix_ff    <= dv_pix_ff[DIV_STAGES];
      end
   end

   // --------------------------------------------------- stage 9: add source
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         mix_in[c] = s8_scaled_ff[c] + s8_pix_ff.src[c];
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_MIX]) begin
         s9_mix_ff   <= mix_in;
         s9_alpha_ff <= s8_pix_ff.alpha;
      end
   end

   // ------------------------------------------ stage 10: premultiply, output
   always_comb begin
      logic [WORK_W:0] prem;
      alpha_round = {1'b0, s9_alpha_ff} + (PIX_W+1)'(s9_alpha_ff[PIX_W-1]);
      for (int c = 0; c < NUM_CHAN; c++) begin
         prem       = (WORK_W+1)'(alpha_round) * (WORK_W+1)'(s9_mix_ff[c]);
         prem_in[c] = prem[WORK_W-1:PIX_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         rsp_rgb_ff   <= prem_in;
         rsp_alpha_ff <= s9_alpha_ff;
      end
   end

   assign rsp_out_red   = rsp_rgb_ff[0];
   assign rsp_out_green = rsp_rgb_ff[1];
   assign rsp_out_blue  = rsp_rgb_ff[2];
   assign rsp_out_alpha = rsp_alpha_ff;

   // remainder must stay below the divisor for an 8-bit quotient
   logic div_entry_ok;
   logic div_exit_ok;
   always_comb begin
      div_entry_ok = 1'b1;
      div_exit_ok  = 1'b1;
      for (int c = 0; c < NUM_CHAN; c++) begin
         if (dv_work_ff[0][c][WORK_W-1:PIX_W] >= dv_div_ff[0]) begin
            div_entry_ok = 1'b0;
         end
         if (dv_work_ff[DIV_STAGES][c][WORK_W-1:PIX_W] >= dv_div_ff[DIV_STAGES]) begin
            div_exit_ok = 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&v_ff) && rsp_stall)
      else $error("input stalled with room in the pipeline");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      v_ff[ST_MUL] |-> dv_div_ff[0] != '0)
      else $error("zero divisor entered the divider");

   a_div_entry_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[ST_MUL] |-> div_entry_ok)
      else $error("dividend high byte not below divisor");

   a_div_exit_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[ST_MUL+DIV_STAGES] |-> div_exit_ok)
      else $error("divider remainder out of range");

   a_stalled_out_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && (&v_ff) |=> (&v_ff))
      else $error("full pipeline lost a transaction under stall");
`endif

endmodule
